### rtl/plti_pkg.sv
package plti_pkg;

	// Item kinds on the input stream
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_EMPTY     = 3'd1;
	localparam status_t ST_UNORDERED = 3'd2;
	localparam status_t ST_DECREASED = 3'd3;
	localparam status_t ST_BELOW     = 3'd4;
	localparam status_t ST_ABOVE     = 3'd5;
	localparam status_t ST_FULL      = 3'd6;

	// Fixed field widths
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int NUM_W  = 66;
	localparam int QUO_W  = 33;
	localparam int DIV_STEPS = 33;

endpackage

### rtl/piecewise_linear_table_interp_unit.sv
// Channel  Dir  Signals                      Content
// s_       in   tvalid tready tdata tuser    load or query transaction
// m_       out  tvalid tready tdata tuser    interpolated value and status
//
// A load or a flagged query goes from S_IDLE straight to S_OUT. A query that
// hits the key under the walk pointer passes S_RK, S_CK and S_HIT. A full
// interpolation walks the table, reads both points, sums two products in
// S_M1 and S_M2 and runs the 33-step restoring divider; the table walk reads
// one key RAM entry per cycle. Reset clears all registers, not the tables.
// A result waiting on m_tready holds the unit in its output state.
module piecewise_linear_table_interp_unit #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key[31:0], point_value[63:32]
	input  logic [1:0]  s_tuser,   // cmd[0], restart[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_value[31:0]
	output logic [2:0]  m_tuser    // status[2:0]
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RK, S_CK, S_HIT, S_V1, S_V0, S_M1, S_M2, S_ABS, S_DIV, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	logic [CW-1:0]                   count_q;
	logic                            ordered_q;
	logic [AW-1:0]                   walk_q;
	logic signed [31:0]              prev_q;
	logic                            run_q;
	logic signed [31:0]              first_key_q;
	logic signed [31:0]              last_key_q;

	logic [AW-1:0]                   i_q;
	logic                            first_q;
	logic signed [31:0]              key_q;
	logic signed [31:0]              k1_q;
	logic signed [31:0]              k0_q;
	logic signed [31:0]              v1_q;
	logic signed [31:0]              v0_q;
	logic signed [plti_pkg::NUM_W-1:0] acc_q;
	logic [plti_pkg::QUO_W-1:0]      div_q;
	logic [plti_pkg::QUO_W-1:0]      rem_q;
	logic [plti_pkg::QUO_W-1:0]      quo_q;
	logic                            neg_q;
	logic [5:0]                      step_q;
	logic [31:0]                     res_q;
	plti_pkg::status_t               st_q;
	logic                            m_tvalid_q;
	logic [31:0]                     m_tdata_q;
	plti_pkg::status_t               m_tuser_q;

	// Input fields
	logic                            in_cmd;
	logic                            in_restart;
	logic signed [31:0]              in_key;
	logic [31:0]                     in_val;
	logic                            accept;

	assign in_cmd     = s_tuser[0];
	assign in_restart = s_tuser[1];
	assign in_key     = $signed(s_tdata[31:0]);
	assign in_val     = s_tdata[63:32];
	assign s_tready   = (state_q == S_IDLE);
	assign accept     = s_tvalid && s_tready;

	// State as seen after the restart effects
	logic [CW-1:0]      cnt_eff;
	logic               run_eff;
	logic [AW-1:0]      walk_eff;
	logic               full;
	logic               load_we;
	plti_pkg::status_t  q_status;
	logic [AW-1:0]      i_init;

	assign cnt_eff  = (in_restart && in_cmd == plti_pkg::CMD_LOAD) ? '0 : count_q;
	assign run_eff  = run_q && !in_restart;
	assign walk_eff = in_restart ? '0 : walk_q;
	assign full     = (cnt_eff == CW'(TABLE_DEPTH));
	assign load_we  = accept && (in_cmd == plti_pkg::CMD_LOAD) && !full;
	assign i_init   = (CW'(walk_eff) >= count_q) ? '0 : walk_eff;

	always_comb begin
		if (count_q == '0) begin
			q_status = plti_pkg::ST_EMPTY;
		end else if (!ordered_q) begin
			q_status = plti_pkg::ST_UNORDERED;
		end else if (run_eff && in_key < prev_q) begin
			q_status = plti_pkg::ST_DECREASED;
		end else if (in_key < first_key_q) begin
			q_status = plti_pkg::ST_BELOW;
		end else if (in_key > last_key_q) begin
			q_status = plti_pkg::ST_ABOVE;
		end else begin
			q_status = plti_pkg::ST_OK;
		end
	end

	// Table memories
	logic [AW-1:0]      key_addr;
	logic [AW-1:0]      val_addr;
	logic [31:0]        key_rdata;
	logic [31:0]        val_rdata;
	logic signed [31:0] ck;
	logic               hit;
	logic               adv;

	assign ck  = $signed(key_rdata);
	assign hit = first_q && (ck == key_q);
	assign adv = !hit && (ck < key_q) && ((CW'(i_q) + CW'(1)) < count_q);

	always_comb begin
		case (state_q)
			S_IDLE: begin
				key_addr = cnt_eff[AW-1:0];
				val_addr = cnt_eff[AW-1:0];
			end
			S_CK: begin
				key_addr = adv ? i_q + AW'(1) : i_q - AW'(1);
				val_addr = i_q;
			end
			S_V1: begin
				key_addr = i_q;
				val_addr = i_q - AW'(1);
			end
			default: begin
				key_addr = i_q;
				val_addr = i_q;
			end
		endcase
	end

	plti_ram #(.WIDTH(plti_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (load_we),
		.addr  (key_addr),
		.wdata (s_tdata[31:0]),
		.rdata (key_rdata)
	);

	plti_ram #(.WIDTH(plti_pkg::VAL_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (load_we),
		.addr  (val_addr),
		.wdata (in_val),
		.rdata (val_rdata)
	);

	// Shared multiplier: distance times table value
	logic signed [32:0] seg_dist;
	logic signed [31:0] mval;
	logic signed [64:0] prod;
	logic signed [32:0] width;

	assign width    = {k1_q[31], k1_q} - {k0_q[31], k0_q};
	assign seg_dist = (state_q == S_M1) ? ({key_q[31], key_q} - {k0_q[31], k0_q})
	                                    : ({k1_q[31], k1_q} - {key_q[31], key_q});
	assign mval     = (state_q == S_M1) ? v1_q : v0_q;
	assign prod     = seg_dist * mval;

	// Restoring divider step
	logic [plti_pkg::QUO_W:0] trial;
	logic                     fits;

	assign trial = {rem_q, quo_q[plti_pkg::QUO_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	logic [plti_pkg::NUM_W-1:0] mag;
	assign mag = acc_q[plti_pkg::NUM_W-1] ? plti_pkg::NUM_W'(-acc_q) : acc_q;

	// Sequencer, table state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ordered_q   <= 1'b1;
			walk_q      <= '0;
			prev_q      <= '0;
			run_q       <= 1'b0;
			first_key_q <= '0;
			last_key_q  <= '0;
			i_q         <= '0;
			first_q     <= 1'b0;
			key_q       <= '0;
			k1_q        <= '0;
			k0_q        <= '0;
			v1_q        <= '0;
			v0_q        <= '0;
			acc_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			neg_q       <= 1'b0;
			step_q      <= '0;
			res_q       <= '0;
			st_q        <= plti_pkg::ST_OK;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= plti_pkg::ST_OK;
		end else begin
			if (m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						if (in_cmd == plti_pkg::CMD_LOAD) begin
							if (in_restart) begin
								ordered_q <= 1'b1;
								walk_q    <= '0;
								run_q     <= 1'b0;
							end
							if (full) begin
								count_q <= cnt_eff;
								st_q    <= plti_pkg::ST_FULL;
							end else begin
								if (cnt_eff != '0 && in_key < last_key_q) begin
									ordered_q <= 1'b0;
								end
								if (cnt_eff == '0) begin
									first_key_q <= in_key;
								end
								last_key_q <= in_key;
								count_q    <= cnt_eff + CW'(1);
								st_q       <= plti_pkg::ST_OK;
							end
							state_q <= S_OUT;
						end else begin
							st_q <= q_status;
							if (q_status == plti_pkg::ST_OK) begin
								prev_q  <= in_key;
								run_q   <= 1'b1;
								key_q   <= in_key;
								i_q     <= i_init;
								first_q <= 1'b1;
								state_q <= S_RK;
							end else begin
								walk_q  <= walk_eff;
								run_q   <= run_eff;
								state_q <= S_OUT;
							end
						end
					end
				end
				S_RK: begin
					state_q <= S_CK;
				end
				S_CK: begin
					if (adv) begin
						i_q     <= i_q + AW'(1);
						first_q <= 1'b0;
					end else begin
						walk_q <= i_q;
						k1_q   <= ck;
						state_q <= (hit || i_q == '0) ? S_HIT : S_V1;
					end
				end
				S_HIT: begin
					res_q   <= val_rdata;
					state_q <= S_OUT;
				end
				S_V1: begin
					k0_q    <= ck;
					v1_q    <= $signed(val_rdata);
					state_q <= S_V0;
				end
				S_V0: begin
					v0_q <= $signed(val_rdata);
					if (width <= 0) begin
						res_q   <= v1_q;
						state_q <= S_OUT;
					end else begin
						div_q   <= width[plti_pkg::QUO_W-1:0];
						state_q <= S_M1;
					end
				end
				S_M1: begin
					acc_q   <= plti_pkg::NUM_W'(prod);
					state_q <= S_M2;
				end
				S_M2: begin
					acc_q   <= acc_q + plti_pkg::NUM_W'(prod);
					state_q <= S_ABS;
				end
				S_ABS: begin
					neg_q   <= acc_q[plti_pkg::NUM_W-1];
					rem_q   <= mag[plti_pkg::NUM_W-1:plti_pkg::QUO_W];
					quo_q   <= mag[plti_pkg::QUO_W-1:0];
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= fits ? plti_pkg::QUO_W'(trial - {1'b0, div_q})
					               : trial[plti_pkg::QUO_W-1:0];
					quo_q  <= {quo_q[plti_pkg::QUO_W-2:0], fits};
					step_q <= step_q + 6'd1;
					if (step_q == 6'(plti_pkg::DIV_STEPS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_q   <= neg_q ? -quo_q[31:0] : quo_q[31:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						m_tuser_q  <= st_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### rtl/plti_ram.sv
module plti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic [WIDTH-1:0]           wdata,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
